>>> src/phdc_pkg.sv
// ----------------------------------------------------------------------------
// pH dosing controller package
// Shared codes, register indexes and item types for the dosing controller.
// ----------------------------------------------------------------------------
package phdc_pkg;

    // Command codes carried in the input tuser
    localparam logic [2:0] FUNC_UPDATE   = 3'd0;
    localparam logic [2:0] FUNC_MAN_ACID = 3'd1;
    localparam logic [2:0] FUNC_MAN_BASE = 3'd2;
    localparam logic [2:0] FUNC_CIRC     = 3'd3;
    localparam logic [2:0] FUNC_ESTOP    = 3'd4;
    localparam logic [2:0] FUNC_RESUME   = 3'd5;

    // Dose kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BASE = 2'd1;
    localparam logic [1:0] KIND_ACID = 2'd2;

    // Event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_BASE_BLOCKED = 3'd1;
    localparam logic [2:0] EV_ACID_BLOCKED = 3'd2;
    localparam logic [2:0] EV_TIMEOUT      = 3'd3;
    localparam logic [2:0] EV_TARGET       = 3'd4;
    localparam logic [2:0] EV_RES_LOW      = 3'd5;
    localparam logic [2:0] EV_CONTINUE     = 3'd6;

    // Relay bit positions
    localparam int RLY_ACID = 0;
    localparam int RLY_BASE = 1;
    localparam int RLY_CIRC = 2;

    // Configuration register indexes
    localparam logic [2:0] REG_PH_LOW_LIMIT   = 3'd0;
    localparam logic [2:0] REG_PH_HIGH_LIMIT  = 3'd1;
    localparam logic [2:0] REG_PH_LOW_TARGET  = 3'd2;
    localparam logic [2:0] REG_PH_HIGH_TARGET = 3'd3;
    localparam logic [2:0] REG_PULSE_MS       = 3'd4;
    localparam logic [2:0] REG_RECHECK_MS     = 3'd5;
    localparam logic [2:0] REG_SESSION_LIMIT  = 3'd6;
    localparam logic [2:0] REG_ACTIVE_LOW     = 3'd7;

    typedef struct packed {
        logic [10:0] ph_low_limit;
        logic [10:0] ph_high_limit;
        logic [10:0] ph_low_target;
        logic [10:0] ph_high_target;
        logic [31:0] pulse_ms;
        logic [31:0] recheck_ms;
        logic [31:0] session_limit_ms;
        logic        relay_active_low;
    } phdc_cfg_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_ms;
        logic [10:0] ph_value;
        logic        acid_level_ok;
        logic        base_level_ok;
        logic        switch_on;
    } phdc_item_t;

    // Control state apart from the time stamps, whose width is a parameter
    typedef struct packed {
        logic       dosing;
        logic [1:0] kind;
        logic       emergency;
        logic [2:0] relay_on;
    } phdc_state_t;

    typedef struct packed {
        logic        acid_pin;
        logic        base_pin;
        logic        circ_pin;
        logic [1:0]  dose_kind;
        logic        dosing;
        logic        emergency;
        logic [2:0]  event_code;
        logic [31:0] pulse_elapsed_ms;
        logic [31:0] session_elapsed_ms;
    } phdc_result_t;

endpackage

>>> src/phdc_core.sv
// ----------------------------------------------------------------------------
// pH dosing controller step logic
// Computes the next controller state and the result item for one command.
// ----------------------------------------------------------------------------
module phdc_core
    import phdc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  phdc_cfg_t            cfg,
    input  phdc_item_t           item,
    input  phdc_state_t          state,
    input  logic [TIME_BITS-1:0] pulse_stamp,
    input  logic [TIME_BITS-1:0] session_stamp,
    output phdc_state_t          state_next,
    output logic [TIME_BITS-1:0] pulse_stamp_next,
    output logic [TIME_BITS-1:0] session_stamp_next,
    output phdc_result_t         result
);

    // Compare width: wide enough for both the time stamps and the 32-bit limits
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [CW-1:0]        now_ext;
    logic [CW-1:0]        recheck_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] sess_d;
    logic [TIME_BITS-1:0] pulse_d;
    logic                 ph_low;
    logic                 ph_high;
    logic                 sess_timeout;
    logic                 pulse_done;
    logic                 level_ok;
    logic                 reached;
    logic [2:0]           ev;
    logic [TIME_BITS-1:0] pe_d;
    logic [CW-1:0]        pe_val;
    logic [CW-1:0]        se_val;

    assign now_ext     = CW'(item.now_ms);
    assign recheck_ext = CW'(cfg.recheck_ms);
    assign now_t       = now_ext[TIME_BITS-1:0];
    assign sess_d      = now_t - session_stamp;
    assign pulse_d     = now_t - pulse_stamp;

    assign ph_low       = item.ph_value < cfg.ph_low_limit;
    assign ph_high      = item.ph_value > cfg.ph_high_limit;
    assign sess_timeout = CW'(sess_d) >= CW'(cfg.session_limit_ms);
    // A stamp in the future (recheck wait) reads as negative: not finished yet.
    assign pulse_done   = !pulse_d[TIME_BITS-1] && (CW'(pulse_d) >= CW'(cfg.pulse_ms));
    assign level_ok     = (state.kind == KIND_BASE) ? item.base_level_ok : item.acid_level_ok;
    assign reached      = (state.kind == KIND_BASE) ?
                          (item.ph_value >= cfg.ph_low_target) :
                          (item.ph_value <= cfg.ph_high_target);

    always_comb
    begin
        state_next         = state;
        pulse_stamp_next   = pulse_stamp;
        session_stamp_next = session_stamp;
        ev                 = EV_NONE;

        case (item.func)
            FUNC_UPDATE:
            begin
                if (!state.emergency)
                begin
                    if (!state.dosing)
                    begin
                        if (ph_low && item.base_level_ok)
                        begin
                            state_next.kind               = KIND_BASE;
                            state_next.relay_on[RLY_BASE] = 1'b1;
                            state_next.relay_on[RLY_ACID] = 1'b0;
                            state_next.dosing             = 1'b1;
                            pulse_stamp_next              = now_t;
                            session_stamp_next            = now_t;
                        end
                        else if (ph_high && item.acid_level_ok)
                        begin
                            state_next.kind               = KIND_ACID;
                            state_next.relay_on[RLY_ACID] = 1'b1;
                            state_next.relay_on[RLY_BASE] = 1'b0;
                            state_next.dosing             = 1'b1;
                            pulse_stamp_next              = now_t;
                            session_stamp_next            = now_t;
                        end
                        else if (ph_low)
                        begin
                            ev = EV_BASE_BLOCKED;
                        end
                        else if (ph_high)
                        begin
                            ev = EV_ACID_BLOCKED;
                        end
                    end
                    else if (sess_timeout)
                    begin
                        state_next.relay_on[RLY_ACID] = 1'b0;
                        state_next.relay_on[RLY_BASE] = 1'b0;
                        state_next.kind               = KIND_NONE;
                        state_next.dosing             = 1'b0;
                        ev                            = EV_TIMEOUT;
                    end
                    else if (pulse_done)
                    begin
                        if ((state.kind == KIND_BASE || state.kind == KIND_ACID) &&
                            (!level_ok || reached))
                        begin
                            state_next.relay_on[RLY_ACID] = 1'b0;
                            state_next.relay_on[RLY_BASE] = 1'b0;
                            state_next.kind               = KIND_NONE;
                            state_next.dosing             = 1'b0;
                            ev = !level_ok ? EV_RES_LOW : EV_TARGET;
                        end
                        else
                        begin
                            pulse_stamp_next = now_t + recheck_ext[TIME_BITS-1:0];
                            ev               = EV_CONTINUE;
                        end
                    end
                end
            end
            FUNC_MAN_ACID:
            begin
                if (item.switch_on)
                begin
                    state_next.kind               = KIND_ACID;
                    state_next.relay_on[RLY_ACID] = 1'b1;
                    state_next.relay_on[RLY_BASE] = 1'b0;
                    state_next.dosing             = 1'b1;
                    pulse_stamp_next              = now_t;
                    session_stamp_next            = now_t;
                end
                else
                begin
                    state_next.relay_on[RLY_ACID] = 1'b0;
                    if (state.kind == KIND_ACID)
                    begin
                        state_next.kind   = KIND_NONE;
                        state_next.dosing = 1'b0;
                    end
                end
            end
            FUNC_MAN_BASE:
            begin
                if (item.switch_on)
                begin
                    state_next.kind               = KIND_BASE;
                    state_next.relay_on[RLY_BASE] = 1'b1;
                    state_next.relay_on[RLY_ACID] = 1'b0;
                    state_next.dosing             = 1'b1;
                    pulse_stamp_next              = now_t;
                    session_stamp_next            = now_t;
                end
                else
                begin
                    state_next.relay_on[RLY_BASE] = 1'b0;
                    if (state.kind == KIND_BASE)
                    begin
                        state_next.kind   = KIND_NONE;
                        state_next.dosing = 1'b0;
                    end
                end
            end
            FUNC_CIRC:
            begin
                state_next.relay_on[RLY_CIRC] = item.switch_on;
            end
            FUNC_ESTOP:
            begin
                if (!state.emergency)
                begin
                    state_next.emergency = 1'b1;
                    state_next.relay_on  = 3'b000;
                    state_next.kind      = KIND_NONE;
                    state_next.dosing    = 1'b0;
                end
            end
            FUNC_RESUME:
            begin
                // Only circulation comes back; the pump relays keep their value.
                if (state.emergency)
                begin
                    state_next.emergency          = 1'b0;
                    state_next.relay_on[RLY_CIRC] = 1'b1;
                    state_next.kind               = KIND_NONE;
                    state_next.dosing             = 1'b0;
                end
            end
            default:
            begin
                ev = EV_NONE;
            end
        endcase
    end

    // Elapsed times are reported against the state left by this item.
    assign pe_d = now_t - pulse_stamp_next;

    always_comb
    begin
        pe_val = '0;
        se_val = '0;
        if (state_next.dosing)
        begin
            if (!pe_d[TIME_BITS-1])
            begin
                pe_val = (CW'(pe_d) >= CW'(cfg.pulse_ms)) ? CW'(cfg.pulse_ms) : CW'(pe_d);
            end
            se_val = CW'(TIME_BITS'(now_t - session_stamp_next));
        end
    end

    assign result.acid_pin           = state_next.relay_on[RLY_ACID] ^ cfg.relay_active_low;
    assign result.base_pin           = state_next.relay_on[RLY_BASE] ^ cfg.relay_active_low;
    assign result.circ_pin           = state_next.relay_on[RLY_CIRC] ^ cfg.relay_active_low;
    assign result.dose_kind          = state_next.kind;
    assign result.dosing             = state_next.dosing;
    assign result.emergency          = state_next.emergency;
    assign result.event_code         = ev;
    assign result.pulse_elapsed_ms   = pe_val[31:0];
    assign result.session_elapsed_ms = se_val[31:0];

endmodule

>>> src/ph_dosing_controller.sv
// ----------------------------------------------------------------------------
// pH dosing controller
// Bang-bang acid/base dosing with circulation relay, emergency stop and
// manual relay commands; one result item for every command item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                        Contents
//  s_*       in         s_tvalid s_tready s_tdata/tuser command item
//  m_*       out        m_tvalid m_tready m_tdata/tuser result item
//  cfg_*     in         cfg_we cfg_index cfg_data      register write
//
// Each item passes an input register and a result register before it is
// presented on m_*; a new item may enter every cycle while the result
// register is not stalled.
// The controller state is updated as an item moves into the result register.
// A stalled result holds in place; the input register still takes one more
// item behind it. Reset restores the register defaults and the idle state
// with circulation on.
//
module ph_dosing_controller
    import phdc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], ph_value[42:32], acid_level_ok[43], base_level_ok[44],
    // switch_on[45], zero[47:46]
    input  logic [47:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // acid_pin[0], base_pin[1], circ_pin[2], dosing[3], emergency[4],
    // event_code[7:5], pulse_elapsed_ms[39:8], session_elapsed_ms[71:40]
    output logic [71:0] m_tdata,
    // dose_kind[1:0]
    output logic [1:0]  m_tuser,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    phdc_cfg_t            cfg_reg;
    phdc_item_t           in_item_reg;
    logic                 in_valid_reg;
    phdc_state_t          state_reg;
    phdc_state_t          state_next;
    logic [TIME_BITS-1:0] pulse_stamp_reg;
    logic [TIME_BITS-1:0] pulse_stamp_next;
    logic [TIME_BITS-1:0] session_stamp_reg;
    logic [TIME_BITS-1:0] session_stamp_next;
    phdc_result_t         result_next;
    phdc_result_t         out_result_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    phdc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .cfg                (cfg_reg),
        .item               (in_item_reg),
        .state              (state_reg),
        .pulse_stamp        (pulse_stamp_reg),
        .session_stamp      (session_stamp_reg),
        .state_next         (state_next),
        .pulse_stamp_next   (pulse_stamp_next),
        .session_stamp_next (session_stamp_next),
        .result             (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ph_low_limit     <= 11'd550;
            cfg_reg.ph_high_limit    <= 11'd650;
            cfg_reg.ph_low_target    <= 11'd580;
            cfg_reg.ph_high_target   <= 11'd620;
            cfg_reg.pulse_ms         <= 32'd10000;
            cfg_reg.recheck_ms       <= 32'd5000;
            cfg_reg.session_limit_ms <= 32'd300000;
            cfg_reg.relay_active_low <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PH_LOW_LIMIT:   cfg_reg.ph_low_limit     <= cfg_data[10:0];
                REG_PH_HIGH_LIMIT:  cfg_reg.ph_high_limit    <= cfg_data[10:0];
                REG_PH_LOW_TARGET:  cfg_reg.ph_low_target    <= cfg_data[10:0];
                REG_PH_HIGH_TARGET: cfg_reg.ph_high_target   <= cfg_data[10:0];
                REG_PULSE_MS:       cfg_reg.pulse_ms         <= cfg_data;
                REG_RECHECK_MS:     cfg_reg.recheck_ms       <= cfg_data;
                REG_SESSION_LIMIT:  cfg_reg.session_limit_ms <= cfg_data;
                REG_ACTIVE_LOW:     cfg_reg.relay_active_low <= cfg_data[0];
                default:            cfg_reg.relay_active_low <= cfg_reg.relay_active_low;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg.dosing    <= 1'b0;
            state_reg.kind      <= KIND_NONE;
            state_reg.emergency <= 1'b0;
            state_reg.relay_on  <= 3'b100;
            pulse_stamp_reg   <= '0;
            session_stamp_reg <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                state_reg         <= state_next;
                pulse_stamp_reg   <= pulse_stamp_next;
                session_stamp_reg <= session_stamp_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.func          <= s_tuser;
            in_item_reg.now_ms        <= s_tdata[31:0];
            in_item_reg.ph_value      <= s_tdata[42:32];
            in_item_reg.acid_level_ok <= s_tdata[43];
            in_item_reg.base_level_ok <= s_tdata[44];
            in_item_reg.switch_on     <= s_tdata[45];
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.dose_kind;
    assign m_tdata  = {out_result_reg.session_elapsed_ms,
                       out_result_reg.pulse_elapsed_ms,
                       out_result_reg.event_code,
                       out_result_reg.emergency,
                       out_result_reg.dosing,
                       out_result_reg.circ_pin,
                       out_result_reg.base_pin,
                       out_result_reg.acid_pin};

endmodule

>>> src/phdc_checker.sv
// ----------------------------------------------------------------------------
// pH dosing controller port checker
// Watches the top-level ports for consistency of the result items.
// ----------------------------------------------------------------------------
module phdc_port_props
    import phdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result item must stay on the bus unchanged.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // A session is in progress exactly when a dose kind is set.
    a_dosing_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tuser != KIND_NONE)))
        else $error("dosing flag and dose kind disagree");

    // Elapsed times read zero outside a session.
    a_idle_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[71:8] == 64'd0)
        else $error("elapsed time reported while idle");

    // Updates are ignored while the emergency stop holds, so no event is raised.
    // Manual commands still act then, so a session may be running.
    a_emergency_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[7:5] == EV_NONE)
        else $error("event reported during emergency");

endmodule

bind ph_dosing_controller phdc_port_props u_phdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/phdc_checker.sv
// ----------------------------------------------------------------------------
// pH dosing controller checker
// Watches the command, result and register-write channels, keeps its own copy
// of the controller state and settings, predicts the result of every accepted
// command item and compares it field by field with the results that come out.
// ----------------------------------------------------------------------------
module phdc_checker
    import phdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    phdc_cfg_t    cfg;
    logic         dosing_st;
    logic [1:0]   kind_st;
    logic [31:0]  pulse_at;
    logic [31:0]  session_at;
    logic         estop_st;
    logic [2:0]   relays;
    phdc_result_t due_q[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t: %s is %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic void end_session();
        relays[RLY_ACID] = 1'b0;
        relays[RLY_BASE] = 1'b0;
        kind_st = KIND_NONE;
        dosing_st = 1'b0;
    endfunction

    function automatic void start_session(input logic [1:0] kind, input logic [31:0] now);
        kind_st = kind;
        relays[RLY_BASE] = (kind == KIND_BASE);
        relays[RLY_ACID] = (kind != KIND_BASE);
        pulse_at = now;
        session_at = now;
        dosing_st = 1'b1;
    endfunction

    function automatic void manual_switch(input logic [1:0] kind, input logic sw,
                                          input logic [31:0] now);
        if (sw)
        begin
            start_session(kind, now);
        end
        else
        begin
            if (kind == KIND_BASE)
                relays[RLY_BASE] = 1'b0;
            else
                relays[RLY_ACID] = 1'b0;
            // Switching off the other pump leaves the session alone.
            if (kind_st == kind)
            begin
                kind_st = KIND_NONE;
                dosing_st = 1'b0;
            end
        end
    endfunction

    function automatic logic [2:0] run_update(input phdc_item_t it);
        logic        below;
        logic        above;
        logic        supply_ok;
        logic        settled;
        logic [31:0] since_pulse;
        logic [31:0] on_for;
        below = it.ph_value < cfg.ph_low_limit;
        above = it.ph_value > cfg.ph_high_limit;
        since_pulse = it.now_ms - pulse_at;
        on_for = it.now_ms - session_at;
        if (estop_st)
            return EV_NONE;
        if (!dosing_st)
        begin
            // Base takes priority when both thresholds are crossed.
            if (below && it.base_level_ok)
                start_session(KIND_BASE, it.now_ms);
            else if (above && it.acid_level_ok)
                start_session(KIND_ACID, it.now_ms);
            else if (below)
                return EV_BASE_BLOCKED;
            else if (above)
                return EV_ACID_BLOCKED;
            return EV_NONE;
        end
        if (on_for >= cfg.session_limit_ms)
        begin
            end_session();
            return EV_TIMEOUT;
        end
        // A pulse stamp in the future (recheck wait) reads as negative.
        if (since_pulse[31] || since_pulse < cfg.pulse_ms)
            return EV_NONE;
        if (kind_st == KIND_BASE || kind_st == KIND_ACID)
        begin
            supply_ok = (kind_st == KIND_BASE) ? it.base_level_ok : it.acid_level_ok;
            settled = (kind_st == KIND_BASE) ? (it.ph_value >= cfg.ph_low_target)
                                             : (it.ph_value <= cfg.ph_high_target);
            if (!supply_ok)
            begin
                end_session();
                return EV_RES_LOW;
            end
            if (settled)
            begin
                end_session();
                return EV_TARGET;
            end
        end
        pulse_at = it.now_ms + cfg.recheck_ms;
        return EV_CONTINUE;
    endfunction

    function automatic phdc_result_t dose_step(input phdc_item_t it);
        phdc_result_t r;
        logic [2:0]   ev;
        logic [2:0]   pins;
        logic [31:0]  since_pulse;
        ev = EV_NONE;
        case (it.func)
            FUNC_UPDATE:   ev = run_update(it);
            FUNC_MAN_ACID: manual_switch(KIND_ACID, it.switch_on, it.now_ms);
            FUNC_MAN_BASE: manual_switch(KIND_BASE, it.switch_on, it.now_ms);
            FUNC_CIRC:     relays[RLY_CIRC] = it.switch_on;
            FUNC_ESTOP:
                if (!estop_st)
                begin
                    estop_st = 1'b1;
                    relays = '0;
                    kind_st = KIND_NONE;
                    dosing_st = 1'b0;
                end
            FUNC_RESUME:
                if (estop_st)
                begin
                    // Only circulation comes back; pump relays keep their value.
                    estop_st = 1'b0;
                    relays[RLY_CIRC] = 1'b1;
                    kind_st = KIND_NONE;
                    dosing_st = 1'b0;
                end
            default: ;
        endcase
        r = '0;
        pins = relays ^ {3{cfg.relay_active_low}};
        r.acid_pin = pins[RLY_ACID];
        r.base_pin = pins[RLY_BASE];
        r.circ_pin = pins[RLY_CIRC];
        r.dose_kind = kind_st;
        r.dosing = dosing_st;
        r.emergency = estop_st;
        r.event_code = ev;
        if (dosing_st)
        begin
            since_pulse = it.now_ms - pulse_at;
            if (!since_pulse[31])
                r.pulse_elapsed_ms = (since_pulse >= cfg.pulse_ms) ? cfg.pulse_ms : since_pulse;
            r.session_elapsed_ms = it.now_ms - session_at;
        end
        return r;
    endfunction

    task automatic check_result(input phdc_result_t got, input phdc_result_t want);
        if (got.acid_pin !== want.acid_pin)
            report_mismatch("acid_pin", 32'(got.acid_pin), 32'(want.acid_pin));
        if (got.base_pin !== want.base_pin)
            report_mismatch("base_pin", 32'(got.base_pin), 32'(want.base_pin));
        if (got.circ_pin !== want.circ_pin)
            report_mismatch("circ_pin", 32'(got.circ_pin), 32'(want.circ_pin));
        if (got.dose_kind !== want.dose_kind)
            report_mismatch("dose_kind", 32'(got.dose_kind), 32'(want.dose_kind));
        if (got.dosing !== want.dosing)
            report_mismatch("dosing", 32'(got.dosing), 32'(want.dosing));
        if (got.emergency !== want.emergency)
            report_mismatch("emergency", 32'(got.emergency), 32'(want.emergency));
        if (got.event_code !== want.event_code)
            report_mismatch("event_code", 32'(got.event_code), 32'(want.event_code));
        if (got.pulse_elapsed_ms !== want.pulse_elapsed_ms)
            report_mismatch("pulse_elapsed_ms", got.pulse_elapsed_ms, want.pulse_elapsed_ms);
        if (got.session_elapsed_ms !== want.session_elapsed_ms)
            report_mismatch("session_elapsed_ms", got.session_elapsed_ms,
                            want.session_elapsed_ms);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        phdc_item_t   cmd;
        phdc_result_t seen;
        if (!rst_n)
        begin
            cfg.ph_low_limit = 11'd550;
            cfg.ph_high_limit = 11'd650;
            cfg.ph_low_target = 11'd580;
            cfg.ph_high_target = 11'd620;
            cfg.pulse_ms = 32'd10000;
            cfg.recheck_ms = 32'd5000;
            cfg.session_limit_ms = 32'd300000;
            cfg.relay_active_low = 1'b0;
            dosing_st = 1'b0;
            kind_st = KIND_NONE;
            pulse_at = '0;
            session_at = '0;
            estop_st = 1'b0;
            relays = '0;
            relays[RLY_CIRC] = 1'b1;
            due_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            // Results are retired before new items are queued.
            if (m_tvalid && m_tready)
            begin
                seen.acid_pin = m_tdata[0];
                seen.base_pin = m_tdata[1];
                seen.circ_pin = m_tdata[2];
                seen.dosing = m_tdata[3];
                seen.emergency = m_tdata[4];
                seen.event_code = m_tdata[7:5];
                seen.pulse_elapsed_ms = m_tdata[39:8];
                seen.session_elapsed_ms = m_tdata[71:40];
                seen.dose_kind = m_tuser;
                if (due_q.size() == 0)
                    report_mismatch("unexpected result item", m_tdata[31:0], '0);
                else
                    check_result(seen, due_q.pop_front());
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PH_LOW_LIMIT:   cfg.ph_low_limit = cfg_data[10:0];
                    REG_PH_HIGH_LIMIT:  cfg.ph_high_limit = cfg_data[10:0];
                    REG_PH_LOW_TARGET:  cfg.ph_low_target = cfg_data[10:0];
                    REG_PH_HIGH_TARGET: cfg.ph_high_target = cfg_data[10:0];
                    REG_PULSE_MS:       cfg.pulse_ms = cfg_data;
                    REG_RECHECK_MS:     cfg.recheck_ms = cfg_data;
                    REG_SESSION_LIMIT:  cfg.session_limit_ms = cfg_data;
                    REG_ACTIVE_LOW:     cfg.relay_active_low = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                cmd.func = s_tuser;
                cmd.now_ms = s_tdata[31:0];
                cmd.ph_value = s_tdata[42:32];
                cmd.acid_level_ok = s_tdata[43];
                cmd.base_level_ok = s_tdata[44];
                cmd.switch_on = s_tdata[45];
                due_q.push_back(dose_step(cmd));
            end
            pending = due_q.size();
        end
    end

endmodule

>>> sim/ph_dosing_controller_tb.sv
// ----------------------------------------------------------------------------
// pH dosing controller testbench
// Drives directed and random command items through the controller under
// several register settings, with random gaps on both channels, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module ph_dosing_controller_tb;
    import phdc_pkg::*;

    // Command codes the block does not use; they must change nothing.
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // now_ms[31:0], ph_value[42:32], acid_level_ok[43], base_level_ok[44],
    // switch_on[45], zero[47:46]
    logic [47:0] s_tdata;
    // func[2:0]
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // acid_pin[0], base_pin[1], circ_pin[2], dosing[3], emergency[4],
    // event_code[7:5], pulse_elapsed_ms[39:8], session_elapsed_ms[71:40]
    logic [71:0] m_tdata;
    // dose_kind[1:0]
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;

    bit          steady;
    logic [31:0] now;
    int          lo_lim;
    int          hi_lim;
    int          lo_tgt;
    int          hi_tgt;

    ph_dosing_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    phdc_checker dose_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 14);

    initial
    begin
        #2000000;
        $display("FAIL ph_dosing_controller");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic post(input logic [2:0] func, input logic [31:0] when,
                        input logic [10:0] ph, input logic acid_ok,
                        input logic base_ok, input logic sw);
        while (!steady && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, sw, base_ok, acid_ok, ph, when};
        s_tuser <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(input int lo, input int hi, input int lt, input int ht,
                                 input logic [31:0] pulse, input logic [31:0] recheck,
                                 input logic [31:0] limit, input logic active_low);
        settle();
        write_reg(REG_PH_LOW_LIMIT, lo);
        write_reg(REG_PH_HIGH_LIMIT, hi);
        write_reg(REG_PH_LOW_TARGET, lt);
        write_reg(REG_PH_HIGH_TARGET, ht);
        write_reg(REG_PULSE_MS, pulse);
        write_reg(REG_RECHECK_MS, recheck);
        write_reg(REG_SESSION_LIMIT, limit);
        write_reg(REG_ACTIVE_LOW, {31'd0, active_low});
        lo_lim = lo;
        hi_lim = hi;
        lo_tgt = lt;
        hi_tgt = ht;
    endtask

    task automatic random_run(input int count, input int step_max);
        int          n;
        int          pick;
        int          v;
        int          jitter;
        logic [2:0]  f;
        for (n = 0; n < count; n++)
        begin
            // Now and then hold off until the block has delivered everything.
            if ($urandom_range(399) == 0)
                settle();
            pick = $urandom_range(99);
            if (pick < 70)
                f = FUNC_UPDATE;
            else if (pick < 78)
                f = FUNC_MAN_ACID;
            else if (pick < 86)
                f = FUNC_MAN_BASE;
            else if (pick < 91)
                f = FUNC_CIRC;
            else if (pick < 94)
                f = FUNC_ESTOP;
            else if (pick < 97)
                f = FUNC_RESUME;
            else
                f = 3'($urandom_range(7));
            if ($urandom_range(99) < 3)
                now = $urandom();
            else
                now = now + $urandom_range(step_max);
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // Most readings sit close to a threshold or a target.
                case ($urandom_range(3))
                    0: v = lo_lim;
                    1: v = hi_lim;
                    2: v = lo_tgt;
                    default: v = hi_tgt;
                endcase
                jitter = $urandom_range(40);
                v = v + jitter - 20;
                if (v < 0)
                    v = 0;
                if (v > 2047)
                    v = 2047;
            end
            else if (pick < 90)
                v = $urandom_range(1400);
            else
                v = $urandom_range(2047);
            post(f, now, v[10:0], $urandom_range(99) < 85, $urandom_range(99) < 85,
                 1'($urandom_range(1)));
        end
    endtask

    initial
    begin : stimulus
        int p;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        now = '0;
        lo_lim = 550;
        hi_lim = 650;
        lo_tgt = 580;
        hi_tgt = 620;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part with the register defaults: a full acid session with
        // a recheck wait, blocked starts, low reservoir, timeout, manual
        // commands, emergency handling and unused codes.
        post(FUNC_UPDATE, 32'd1000, 11'd700, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd5000, 11'd700, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd11000, 11'd700, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd12000, 11'd700, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd26000, 11'd600, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd27000, 11'd500, 1'b1, 1'b0, 1'b0);
        post(FUNC_UPDATE, 32'd28000, 11'd700, 1'b0, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd30000, 11'd500, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd40000, 11'd500, 1'b1, 1'b0, 1'b0);
        post(FUNC_UPDATE, 32'd50000, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd400000, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_MAN_ACID, 32'd400100, 11'd0, 1'b1, 1'b1, 1'b1);
        post(FUNC_MAN_BASE, 32'd400200, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_MAN_ACID, 32'd400300, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_CIRC, 32'd400400, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_CIRC, 32'd400500, 11'd0, 1'b1, 1'b1, 1'b1);
        post(FUNC_MAN_BASE, 32'd400600, 11'd0, 1'b1, 1'b1, 1'b1);
        post(FUNC_ESTOP, 32'd400700, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_ESTOP, 32'd400800, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_UPDATE, 32'd400900, 11'd2047, 1'b1, 1'b1, 1'b0);
        post(FUNC_MAN_ACID, 32'd401000, 11'd0, 1'b1, 1'b1, 1'b1);
        post(FUNC_RESUME, 32'd401100, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_RESUME, 32'd401200, 11'd0, 1'b1, 1'b1, 1'b0);
        post(FUNC_SPARE_LO, 32'hFFFF_FFFF, 11'd2047, 1'b1, 1'b1, 1'b1);
        post(FUNC_SPARE_HI, 32'd0, 11'd0, 1'b0, 1'b0, 1'b0);

        // Defaults again, with no random gaps on either channel.
        now = 32'd500000;
        steady = 1'b1;
        random_run(250, 6000);
        steady = 1'b0;

        // Short pulses and sessions across the time stamp wrap.
        load_settings(550, 650, 580, 620, 32'd50, 32'd20, 32'd400, 1'b1);
        now = 32'hFFFF_F000;
        random_run(300, 40);

        // Widest band, zero pulse and recheck, session limit never reached.
        load_settings(0, 1400, 0, 1400, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        random_run(200, 100);

        // Both thresholds crossed, endless pulse and immediate timeout.
        load_settings(1400, 0, 1400, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
        random_run(150, 1000);

        // A recheck of half the time range puts the next pulse stamp where it reads as still in the future.
        load_settings(600, 600, 600, 600, 32'd30, 32'h8000_0000, 32'd2000, 1'b0);
        random_run(150, 50);

        for (p = 0; p < 4; p++)
        begin
            load_settings($urandom_range(700, 400), $urandom_range(800, 500),
                          $urandom_range(700, 450), $urandom_range(750, 500),
                          $urandom_range(200, 1), $urandom_range(200),
                          $urandom_range(3000, 100), 1'($urandom_range(1)));
            random_run(250, $urandom_range(150, 20));
        end

        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS ph_dosing_controller");
        else
            $display("FAIL ph_dosing_controller");
        $finish;
    end

endmodule
